### src/r2f_pkg.sv
// Shared constants for the radix-2 forward FFT unit.
// No dependencies; used by the top level and its port checker.
`timescale 1ns / 1ps

package r2f_pkg;

  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned OUT_WIDTH    = 28;
  localparam int unsigned IDX_WIDTH    = 10;
  localparam int unsigned CFG_WIDTH    = 4;
  localparam int unsigned OUT_TDATA_W  = 72;
  localparam int unsigned IN_TDATA_W   = 16;

  localparam logic [CFG_WIDTH-1:0] CFG_RESET = 4'd10;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

endpackage

### src/radix2_fft_forward_unit.sv
// Radix-2 decimation-in-time forward FFT over one in-place sample memory.
// Depends on r2f_pkg.
`timescale 1ns / 1ps

// Load transfers (tuser 0) write one real sample each. After the N-th sample the
// unit stops accepting input, bit-reverse reorders the memory by swapping pairs,
// and runs log2(N) stages of N/2 butterflies through the single write port of
// the {imag, real} memory: two reads, multiply, round and add, then two writes.
// Read transfers (tuser 1) then return bins in natural order, each through a
// memory read and then the output register; a new read is not taken while the
// last bin is pending or the output is stalled. tlast marks bin N-1. Reads while
// loading and loads during readout are dropped. N = 2^points_log2, clamped to 1..log2(MAX_POINTS).
module radix2_fft_forward_unit #(
  parameter int unsigned MAX_POINTS   = 1024,
  parameter int unsigned TWIDDLE_BITS = 16,
  parameter int unsigned DATA_WIDTH   = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sample[15:0]
  input  logic [0:0]  s_axis_tuser,   // op[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // bin_real[27:0], bin_imag[55:28], bin_index[65:56]
  output logic        m_axis_tlast    // last
);

  localparam int unsigned AW      = $clog2(MAX_POINTS);
  localparam int unsigned LOG_MAX = AW;
  localparam int unsigned LW      = $clog2(LOG_MAX + 1);
  localparam int unsigned QTR     = MAX_POINTS / 4;
  localparam int unsigned QW      = AW - 1;
  localparam int unsigned FRAC    = TWIDDLE_BITS - 1;
  localparam int unsigned PW      = DATA_WIDTH + TWIDDLE_BITS;
  localparam int unsigned DW      = DATA_WIDTH;
  localparam int unsigned OW      = r2f_pkg::OUT_WIDTH;

  typedef logic [TWIDDLE_BITS-2:0] rom_t [QTR+1];

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    for (int unsigned t = 0; t <= QTR; t++) begin
      x    = (64'd2 * r2f_pkg::PI_Q30 * 64'(t) + 64'(MAX_POINTS / 2)) / MAX_POINTS;
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
      term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
      term = ((term * x2) >> 30) / 64'd342; sum = sum - term;
      r    = (sum + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
      if (r > (64'd1 << FRAC) - 64'd1) begin
        r = (64'd1 << FRAC) - 64'd1;
      end
      rom[t] = r[TWIDDLE_BITS-2:0];
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  typedef enum logic [2:0] {
    S_LOAD,
    S_ISSUE,
    S_DATA,
    S_SUM,
    S_WR_B,
    S_WR_A,
    S_READ
  } state_e;

  state_e state_q;

  logic [3:0]    cfg_q;
  logic [AW:0]   cnt_q;
  logic [AW:0]   rc_q;
  logic [LW-1:0] lg_q;
  logic          mode_q;
  logic [LW-1:0] l_q;
  logic [AW-1:0] i_q;
  logic [AW-1:0] j_q;
  logic [AW-1:0] addr_b_q;
  logic          pend_q;
  logic          pend_last_q;
  logic [r2f_pkg::IDX_WIDTH-1:0] pend_idx_q;

  logic signed [TWIDDLE_BITS-1:0] tw_c_q, tw_s_q;
  logic triv0_q, trivq_q;
  logic signed [PW-1:0] pr_ac_q, pr_bs_q, pr_bc_q, pr_as_q;
  logic [DW-1:0] tr_q, ti_q;

  logic          ovalid_q;
  logic [OW-1:0] out_re_q, out_im_q;
  logic [r2f_pkg::IDX_WIDTH-1:0] out_idx_q;
  logic          out_last_q;

  logic [2*DW-1:0] mem [MAX_POINTS];
  logic [2*DW-1:0] rd_a_q, rd_b_q;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [2*DW-1:0] wdata;
  logic            re_ab;
  logic            re_read;
  logic [AW-1:0]   raddr_a, raddr_b;

  logic [LW-1:0] lg_act;
  logic [AW:0]   n_act, n_run;
  logic          in_xfer;
  logic          in_op;
  logic [AW-1:0] rev_full, rev_i;
  logic [AW:0]   half, span, i_sum;
  logic [AW:0]   j_next;
  logic [AW-1:0] ip;
  logic [AW-1:0] k, k_hi, k_lo;
  logic signed [TWIDDLE_BITS-1:0] tw_c, tw_s;

  logic          adv_mode, adv_done;
  logic [LW-1:0] adv_l;
  logic [AW-1:0] adv_i, adv_j;

  logic signed [DW-1:0] a_re, a_im, b_re, b_im;
  logic signed [PW:0]   acc_r, acc_i;
  logic [DW-1:0]        t_r, t_i;
  logic [DW+OW-1:0]     ext_re, ext_im;

  localparam logic signed [PW:0] RND = (PW + 1)'(1) << (FRAC - 1);

  always_comb begin
    if (cfg_q < 4'd1) begin
      lg_act = LW'(1);
    end else if (cfg_q > 4'(LOG_MAX)) begin
      lg_act = LW'(LOG_MAX);
    end else begin
      lg_act = LW'(cfg_q);
    end
    n_act = (AW + 1)'(1) << lg_act;
    n_run = (AW + 1)'(1) << lg_q;
  end

  assign in_op   = s_axis_tuser[0];
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  always_comb begin
    for (int b = 0; b < AW; b++) begin
      rev_full[b] = i_q[AW-1-b];
    end
    rev_i  = rev_full >> (LW'(AW) - lg_q);
    half   = (AW + 1)'(1) << (l_q - LW'(1));
    span   = half << 1;
    ip     = i_q + half[AW-1:0];
    i_sum  = {1'b0, i_q} + span;
    j_next = {1'b0, j_q} + (AW + 1)'(1);
    k      = j_q << (LW'(LOG_MAX) - l_q);
    k_hi   = AW'(MAX_POINTS / 2) - k;
    k_lo   = k - AW'(QTR);
    if (k <= AW'(QTR)) begin
      tw_s = TWIDDLE_BITS'({1'b0, SINE_ROM[k[QW-1:0]]});
      tw_c = TWIDDLE_BITS'({1'b0, SINE_ROM[QW'(QTR) - k[QW-1:0]]});
    end else begin
      tw_s = TWIDDLE_BITS'({1'b0, SINE_ROM[k_hi[QW-1:0]]});
      tw_c = -TWIDDLE_BITS'({1'b0, SINE_ROM[k_lo[QW-1:0]]});
    end
  end

  always_comb begin
    adv_mode = mode_q;
    adv_done = 1'b0;
    adv_l    = l_q;
    adv_i    = i_q;
    adv_j    = j_q;
    if (!mode_q) begin
      if ({1'b0, i_q} == n_run - (AW + 1)'(1)) begin
        adv_mode = 1'b1;
        adv_l    = LW'(1);
        adv_i    = '0;
        adv_j    = '0;
      end else begin
        adv_i = i_q + AW'(1);
      end
    end else if (i_sum < n_run) begin
      adv_i = i_sum[AW-1:0];
    end else if (j_next < half) begin
      adv_j = j_next[AW-1:0];
      adv_i = j_next[AW-1:0];
    end else if (l_q == lg_q) begin
      adv_done = 1'b1;
    end else begin
      adv_l = l_q + LW'(1);
      adv_j = '0;
      adv_i = '0;
    end
  end

  assign a_re = rd_a_q[DW-1:0];
  assign a_im = rd_a_q[2*DW-1:DW];
  assign b_re = rd_b_q[DW-1:0];
  assign b_im = rd_b_q[2*DW-1:DW];

  always_comb begin
    acc_r = {pr_ac_q[PW-1], pr_ac_q} + {pr_bs_q[PW-1], pr_bs_q} + RND;
    acc_i = {pr_bc_q[PW-1], pr_bc_q} - {pr_as_q[PW-1], pr_as_q} + RND;
    if (triv0_q) begin
      t_r = b_re;
      t_i = b_im;
    end else if (trivq_q) begin
      t_r = b_im;
      t_i = -b_re;
    end else begin
      t_r = acc_r[FRAC +: DW];
      t_i = acc_i[FRAC +: DW];
    end
  end

  always_comb begin
    s_axis_tready = (state_q == S_LOAD) ||
                    ((state_q == S_READ) && !pend_q && (!ovalid_q || m_axis_tready));
    we      = 1'b0;
    waddr   = i_q;
    wdata   = rd_b_q;
    re_ab   = 1'b0;
    re_read = 1'b0;
    raddr_a = i_q;
    raddr_b = mode_q ? ip : rev_i;
    case (state_q)
      S_LOAD: begin
        we    = in_xfer && (in_op == r2f_pkg::OP_LOAD);
        waddr = cnt_q[AW-1:0];
        wdata = {DW'(0), {{(DW - 16){s_axis_tdata[15]}}, s_axis_tdata}};
      end
      S_ISSUE: begin
        re_ab = 1'b1;
      end
      S_WR_B: begin
        we    = 1'b1;
        waddr = addr_b_q;
        if (mode_q) begin
          wdata = {a_im - ti_q, a_re - tr_q};
        end else begin
          wdata = rd_a_q;
        end
      end
      S_WR_A: begin
        we    = 1'b1;
        waddr = i_q;
        if (mode_q) begin
          wdata = {a_im + ti_q, a_re + tr_q};
        end else begin
          wdata = rd_b_q;
        end
      end
      S_READ: begin
        re_read = in_xfer && (in_op == r2f_pkg::OP_READ) && (rc_q < n_act);
        raddr_a = rc_q[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_ab || re_read) begin
      rd_a_q <= mem[raddr_a];
    end
    if (re_ab) begin
      rd_b_q <= mem[raddr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cfg_q       <= r2f_pkg::CFG_RESET;
      cnt_q       <= '0;
      rc_q        <= '0;
      lg_q        <= LW'(1);
      mode_q      <= 1'b0;
      l_q         <= LW'(1);
      i_q         <= '0;
      j_q         <= '0;
      pend_q      <= 1'b0;
      ovalid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      pend_q <= 1'b0;
      case (state_q)
        S_LOAD: begin
          if (in_xfer && (in_op == r2f_pkg::OP_LOAD)) begin
            if (cnt_q + (AW + 1)'(1) >= n_act) begin
              cnt_q   <= '0;
              lg_q    <= lg_act;
              mode_q  <= 1'b0;
              i_q     <= '0;
              state_q <= S_ISSUE;
            end else begin
              cnt_q <= cnt_q + (AW + 1)'(1);
            end
          end
        end
        S_ISSUE: begin
          addr_b_q <= raddr_b;
          tw_c_q   <= tw_c;
          tw_s_q   <= tw_s;
          triv0_q  <= (k == '0);
          trivq_q  <= (k == AW'(QTR));
          if (!mode_q && !(i_q < rev_i)) begin
            mode_q <= adv_mode;
            l_q    <= adv_l;
            i_q    <= adv_i;
            j_q    <= adv_j;
          end else begin
            state_q <= S_DATA;
          end
        end
        S_DATA: begin
          pr_ac_q <= b_re * tw_c_q;
          pr_bs_q <= b_im * tw_s_q;
          pr_bc_q <= b_im * tw_c_q;
          pr_as_q <= b_re * tw_s_q;
          state_q <= mode_q ? S_SUM : S_WR_B;
        end
        S_SUM: begin
          tr_q    <= t_r;
          ti_q    <= t_i;
          state_q <= S_WR_B;
        end
        S_WR_B: begin
          state_q <= S_WR_A;
        end
        S_WR_A: begin
          mode_q <= adv_mode;
          l_q    <= adv_l;
          i_q    <= adv_i;
          j_q    <= adv_j;
          if (adv_done) begin
            rc_q    <= '0;
            state_q <= S_READ;
          end else begin
            state_q <= S_ISSUE;
          end
        end
        S_READ: begin
          if (in_xfer && (in_op == r2f_pkg::OP_READ)) begin
            if (rc_q >= n_act) begin
              rc_q    <= '0;
              state_q <= S_LOAD;
            end else begin
              pend_q      <= 1'b1;
              pend_idx_q  <= r2f_pkg::IDX_WIDTH'(rc_q);
              pend_last_q <= (rc_q == n_act - (AW + 1)'(1));
              if (rc_q + (AW + 1)'(1) >= n_act) begin
                rc_q    <= '0;
                state_q <= S_LOAD;
              end else begin
                rc_q <= rc_q + (AW + 1)'(1);
              end
            end
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
      if (pend_q) begin
        ovalid_q   <= 1'b1;
        out_re_q   <= ext_re[OW-1:0];
        out_im_q   <= ext_im[OW-1:0];
        out_idx_q  <= pend_idx_q;
        out_last_q <= pend_last_q;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign ext_re = {{OW{a_re[DW-1]}}, a_re};
  assign ext_im = {{OW{a_im[DW-1]}}, a_im};

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {6'b0, out_idx_q, out_im_q, out_re_q};
  assign m_axis_tlast  = out_last_q;

endmodule

### src/r2f_checker.sv
// Port-level checks for the radix-2 forward FFT unit, bound to its top level.
// Depends on r2f_pkg and radix2_fft_forward_unit.
`timescale 1ns / 1ps

module r2f_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [3:0]  cfg_wdata_i,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [r2f_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic read_xfer;
  logic [r2f_pkg::IDX_WIDTH-1:0] out_idx;

  assign read_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == r2f_pkg::OP_READ);
  assign out_idx   = m_axis_tdata[65:56];

  a_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  a_hold_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output transfer changed while stalled");

  a_result_follows_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(read_xfer, 2))
    else $error("result without a read transfer two cycles before");

  a_last_not_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> out_idx != '0)
    else $error("final bin flagged on index zero");

endmodule

bind radix2_fft_forward_unit r2f_checker u_r2f_checker (.*);

### dv/tb.sv
// Self-checking bench for radix2_fft_forward_unit: loads real frames, reads bins back.
// Depends on r2f_pkg and the top level; the bin predictor lives in a scoreboard class.
`timescale 1ns / 1ps

module tb;

  localparam int OW = r2f_pkg::OUT_WIDTH;
  localparam int SW = r2f_pkg::SAMPLE_WIDTH;
  localparam int CW = r2f_pkg::CFG_WIDTH;

  typedef struct {
    logic signed [r2f_pkg::OUT_WIDTH-1:0] re;
    logic signed [r2f_pkg::OUT_WIDTH-1:0] im;
    logic [r2f_pkg::IDX_WIDTH-1:0]        idx;
    logic                                 last;
  } bin_t;

  class fft_scoreboard;
    localparam int POINTS  = 1024;
    localparam int QUARTER = POINTS / 4;
    int                                   sine_q15[QUARTER+1];
    logic signed [r2f_pkg::OUT_WIDTH-1:0] re_mem[POINTS];
    logic signed [r2f_pkg::OUT_WIDTH-1:0] im_mem[POINTS];
    logic [r2f_pkg::CFG_WIDTH-1:0]        len_log2;
    int                                   load_cnt;
    int                                   read_cnt;
    bit                                   reading;
    bin_t                                 bins_due[$];
    int                                   mismatches;

    function new();
      longint unsigned x, x2, term, sum, r;
      for (int t = 0; t <= QUARTER; t++) begin
        x = (2 * r2f_pkg::PI_Q30 * t + POINTS / 2) / POINTS;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        term = x;
        sum = x;
        for (int n = 3; n <= 19; n += 2) begin
          term = ((term * x2) >> 30) / longint'(n * (n - 1));
          if ((n & 3) == 3) sum -= term;
          else sum += term;
        end
        r = (sum + (64'd1 << 14)) >> 15;
        if (r > 32767) r = 32767;
        sine_q15[t] = int'(r);
      end
      len_log2 = r2f_pkg::CFG_RESET;
      load_cnt = 0;
      read_cnt = 0;
      reading = 0;
      mismatches = 0;
    endfunction

    function int active_log2();
      int p;
      p = int'(len_log2);
      if (p < 1) p = 1;
      if (p > 10) p = 10;
      return p;
    endfunction

    function void transform(int lg);
      int n, r, half, span, k, ip;
      longint c, s, a, b;
      logic signed [r2f_pkg::OUT_WIDTH-1:0] tr, ti, sw;
      n = 1 << lg;
      for (int i = 0; i < n; i++) begin
        r = 0;
        for (int bt = 0; bt < lg; bt++) r |= ((i >> bt) & 1) << (lg - 1 - bt);
        if (i < r) begin
          sw = re_mem[r]; re_mem[r] = re_mem[i]; re_mem[i] = sw;
          sw = im_mem[r]; im_mem[r] = im_mem[i]; im_mem[i] = sw;
        end
      end
      for (int l = 1; l <= lg; l++) begin
        half = 1 << (l - 1);
        span = half << 1;
        for (int j = 0; j < half; j++) begin
          k = j * (POINTS >> l);
          if (k <= QUARTER) begin
            s = sine_q15[k];
            c = sine_q15[QUARTER - k];
          end else begin
            s = sine_q15[POINTS / 2 - k];
            c = -longint'(sine_q15[k - QUARTER]);
          end
          for (int i = j; i < n; i += span) begin
            ip = i + half;
            a = longint'(re_mem[ip]);
            b = longint'(im_mem[ip]);
            if (k == 0) begin
              tr = OW'(a);
              ti = OW'(b);
            end else if (k == QUARTER) begin
              tr = OW'(b);
              ti = OW'(-a);
            end else begin
              tr = OW'((a * c + b * s + 16384) >>> 15);
              ti = OW'((b * c - a * s + 16384) >>> 15);
            end
            re_mem[ip] = re_mem[i] - tr;
            im_mem[ip] = im_mem[i] - ti;
            re_mem[i] = re_mem[i] + tr;
            im_mem[i] = im_mem[i] + ti;
          end
        end
      end
    endfunction

    function void note_input(logic op, logic signed [r2f_pkg::SAMPLE_WIDTH-1:0] smp);
      int lg, n;
      bin_t bn;
      lg = active_log2();
      n = 1 << lg;
      if (!reading) begin
        if (op == r2f_pkg::OP_LOAD) begin
          re_mem[load_cnt % POINTS] = OW'(smp);
          im_mem[load_cnt % POINTS] = '0;
          load_cnt++;
          if (load_cnt >= n) begin
            transform(lg);
            load_cnt = 0;
            read_cnt = 0;
            reading = 1;
          end
        end
        return;
      end
      if (op == r2f_pkg::OP_LOAD) return;
      if (read_cnt >= n) begin
        read_cnt = 0;
        reading = 0;
        return;
      end
      bn.re = re_mem[read_cnt % POINTS];
      bn.im = im_mem[read_cnt % POINTS];
      bn.idx = read_cnt[r2f_pkg::IDX_WIDTH-1:0];
      bn.last = (read_cnt == n - 1);
      bins_due.push_back(bn);
      read_cnt++;
      if (read_cnt >= n) begin
        read_cnt = 0;
        reading = 0;
      end
    endfunction

    function void check_bin(logic [r2f_pkg::OUT_TDATA_W-1:0] data, logic last);
      bin_t bn;
      if (bins_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected bin transfer: tdata=%h", data);
        return;
      end
      bn = bins_due.pop_front();
      if (data[27:0] !== bn.re || data[55:28] !== bn.im || data[65:56] !== bn.idx ||
          last !== bn.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("bin %0d: exp re=%0d im=%0d idx=%0d last=%b got re=%0d im=%0d idx=%0d last=%b",
                   bn.idx, bn.re, bn.im, bn.idx, bn.last, $signed(data[27:0]),
                   $signed(data[55:28]), data[65:56], last);
      end
    endfunction
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [r2f_pkg::CFG_WIDTH-1:0]     cfg_wdata_i = '0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [r2f_pkg::IN_TDATA_W-1:0]    s_axis_tdata = '0;
  logic [0:0]                        s_axis_tuser = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [r2f_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
  logic                              m_axis_tlast;

  fft_scoreboard sb = new();
  int  sent_cnt = 0;
  int  send_idle_pct = 37;
  int  recv_idle_pct = 59;
  int  quiet_cycles = 0;

  always #10 clk_i = ~clk_i;

  radix2_fft_forward_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_bin(m_axis_tdata, m_axis_tlast);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 200000) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_item(logic op, logic [r2f_pkg::SAMPLE_WIDTH-1:0] smp);
    if (sent_cnt < 400) begin
      send_idle_pct = 37; recv_idle_pct = 59;
    end else if (sent_cnt < 800) begin
      send_idle_pct = 59; recv_idle_pct = 37;
    end else begin
      send_idle_pct = 0; recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= smp;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(op, smp);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  task automatic write_len(logic [r2f_pkg::CFG_WIDTH-1:0] val);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sb.bins_due.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.len_log2 = val;
  endtask

  task automatic run_frame(logic [r2f_pkg::CFG_WIDTH-1:0] val);
    int n;
    logic [r2f_pkg::SAMPLE_WIDTH-1:0] smp;
    write_len(val);
    n = 1 << sb.active_log2();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send_item(r2f_pkg::OP_READ, SW'($urandom));
      case ($urandom_range(7))
        0: smp = 16'h7fff;
        1: smp = 16'h8000;
        2: smp = SW'($urandom_range(15));
        default: smp = SW'($urandom);
      endcase
      send_item(r2f_pkg::OP_LOAD, smp);
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send_item(r2f_pkg::OP_LOAD, SW'($urandom));
      send_item(r2f_pkg::OP_READ, SW'($urandom));
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_len(4'd0);
    send_item(r2f_pkg::OP_READ, 16'h0000);
    send_item(r2f_pkg::OP_LOAD, 16'h7fff);
    send_item(r2f_pkg::OP_LOAD, 16'h8000);
    send_item(r2f_pkg::OP_LOAD, 16'h1234);
    send_item(r2f_pkg::OP_READ, 16'hffff);
    send_item(r2f_pkg::OP_READ, 16'h0000);

    write_len(4'd2);
    send_item(r2f_pkg::OP_LOAD, 16'h7fff);
    send_item(r2f_pkg::OP_LOAD, 16'h8000);
    send_item(r2f_pkg::OP_LOAD, 16'h7fff);
    send_item(r2f_pkg::OP_LOAD, 16'hffff);
    repeat (4) send_item(r2f_pkg::OP_READ, 16'h0000);

    write_len(4'd15);
    repeat (5) send_item(r2f_pkg::OP_LOAD, SW'($urandom));
    write_len(4'd2);
    send_item(r2f_pkg::OP_LOAD, 16'h0100);
    repeat (4) send_item(r2f_pkg::OP_READ, 16'h0000);

    run_frame(4'd1);
    run_frame(4'd8);
    while (sent_cnt < 1200) run_frame(CW'($urandom_range(1, 7)));

    s_axis_tvalid <= 1'b0;
    while (sb.bins_due.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (sb.mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
